[hdl/tir_pkg.sv]
// Shared types and constants for the tachometer interval ring.
package tir_pkg;

   localparam int TICK_BITS        = 32;
   localparam int PULSE_COUNT_BITS = 19;
   localparam int CSR_INDEX_BITS   = 4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_INTERVAL = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE     = 4'd1;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_P_DEB,
      ST_P_GAP,
      ST_P_INC,
      ST_P_SPAN,
      ST_R_GAP,
      ST_R_IDLE,
      ST_R_CHK,
      ST_R_SPAN,
      ST_R_ADD,
      ST_R_OUT
   } state_type;

   // Operation of the shared arithmetic unit.
   typedef enum logic {
      ALU_SUB,
      ALU_ADD
   } alu_op_type;

   // Compare flags of the shared unit, result against the compare operand.
   typedef struct packed {
      logic res_lt_c;
      logic res_gt_c;
   } alu_flags_type;

   // Configuration register values.
   typedef struct packed {
      logic [TICK_BITS-1:0] min_interval;
      logic [TICK_BITS-1:0] debounce;
   } cfg_type;

endpackage

[hdl/tir_slot_mem.sv]
// Interval slot memory with one write port, one registered read port and reset valid bits.
module tir_slot_mem #(
   parameter int DEPTH     = 8,
   parameter int WIDTH     = 80,
   parameter int ADDR_BITS = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array, written without reset.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // One valid bit per entry; an entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/tir_alu.sv]
// Shared add/subtract unit with a compare against a third operand.
module tir_alu (
   input  tir_pkg::alu_op_type            op,
   input  logic [tir_pkg::TICK_BITS-1:0]  a,
   input  logic [tir_pkg::TICK_BITS-1:0]  b,
   input  logic [tir_pkg::TICK_BITS-1:0]  c,
   output logic [tir_pkg::TICK_BITS-1:0]  result,
   output tir_pkg::alu_flags_type         flags
);
   import tir_pkg::*;

   // Wrapping add or subtract, then an unsigned compare of the result.
   always_comb begin
      result = (op == ALU_ADD) ? (a + b) : (a - b);
      flags.res_lt_c = (result < c);
      flags.res_gt_c = (result > c);
   end

endmodule

[hdl/tir_seq.sv]
// Sequencer and working registers for pulse counting and window reads.
module tir_seq #(
   parameter int SLOT_COUNT = 8,
   parameter int COUNT_BITS = 16,
   parameter int IDX_BITS   = 3,
   parameter int ENT_BITS   = 80
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_func,
   input  logic [tir_pkg::TICK_BITS-1:0]         req_sample_time,
   input  logic [tir_pkg::TICK_BITS-1:0]         req_window_request,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [tir_pkg::PULSE_COUNT_BITS-1:0]  rsp_pulse_count,
   output logic [tir_pkg::TICK_BITS-1:0]         rsp_window_length,
   output logic [tir_pkg::TICK_BITS-1:0]         rsp_window_start,
   input  tir_pkg::cfg_type                      cfg,
   output logic                                  mem_rd_en,
   output logic [IDX_BITS-1:0]                   mem_rd_addr,
   input  logic [ENT_BITS-1:0]                   mem_rd_data,
   output logic                                  mem_wr_en,
   output logic [IDX_BITS-1:0]                   mem_wr_addr,
   output logic [ENT_BITS-1:0]                   mem_wr_data,
   output tir_pkg::alu_op_type                   alu_op,
   output logic [tir_pkg::TICK_BITS-1:0]         alu_a,
   output logic [tir_pkg::TICK_BITS-1:0]         alu_b,
   output logic [tir_pkg::TICK_BITS-1:0]         alu_c,
   input  logic [tir_pkg::TICK_BITS-1:0]         alu_result,
   input  tir_pkg::alu_flags_type                alu_flags
);
   import tir_pkg::*;

   localparam int N_BITS = $clog2(SLOT_COUNT + 1);
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SLOT_COUNT - 1);

   state_type state_ff, state_in;

   // Control registers.
   logic [IDX_BITS-1:0] cur_slot_ff, cur_slot_in;
   logic                accepted_once_ff, accepted_once_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Item and working registers.
   logic                        func_ff, func_in;
   logic [TICK_BITS-1:0]        now_ff, now_in;
   logic [TICK_BITS-1:0]        want_ff, want_in;
   logic [TICK_BITS-1:0]        last_accept_ff, last_accept_in;
   logic [COUNT_BITS-1:0]       cnt_ff, cnt_in;
   logic [TICK_BITS-1:0]        start_ff, start_in;
   logic [TICK_BITS-1:0]        end_ff, end_in;
   logic [TICK_BITS-1:0]        gap_ff, gap_in;
   logic [TICK_BITS-1:0]        span_ff, span_in;
   logic [TICK_BITS-1:0]        len_ff, len_in;
   logic [TICK_BITS-1:0]        first_ff, first_in;
   logic [PULSE_COUNT_BITS-1:0] sum_ff, sum_in;
   logic [N_BITS-1:0]           n_ff, n_in;
   logic [IDX_BITS-1:0]         idx_ff, idx_in;

   // Output registers.
   logic [PULSE_COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic [TICK_BITS-1:0]        rsp_len_ff, rsp_len_in;
   logic [TICK_BITS-1:0]        rsp_start_ff, rsp_start_in;

   // Fields of the entry last read from the slot memory.
   logic [COUNT_BITS-1:0] rd_count;
   logic [TICK_BITS-1:0]  rd_start;
   logic [TICK_BITS-1:0]  rd_end;
   logic [TICK_BITS-1:0]  rd_count_wide;
   logic [COUNT_BITS-1:0] cnt_sat;
   logic [IDX_BITS-1:0]   next_slot;
   logic [IDX_BITS-1:0]   prev_idx;
   logic                  accept;
   logic                  drop;
   logic                  rsp_free;

   assign rd_count      = mem_rd_data[ENT_BITS-1:2*TICK_BITS];
   assign rd_start      = mem_rd_data[2*TICK_BITS-1:TICK_BITS];
   assign rd_end        = mem_rd_data[TICK_BITS-1:0];
   assign rd_count_wide = TICK_BITS'(rd_count);
   assign cnt_sat       = (cnt_ff == '1) ? cnt_ff : cnt_ff + 1'b1;
   assign next_slot     = (cur_slot_ff == LAST_IDX) ? '0 : cur_slot_ff + 1'b1;
   assign prev_idx      = (idx_ff == '0) ? LAST_IDX : idx_ff - 1'b1;
   assign accept        = req_valid && (state_ff == ST_IDLE);
   assign drop          = (cfg.debounce != '0) && accepted_once_ff && alu_flags.res_lt_c;
   assign rsp_free      = !rsp_valid_ff || !rsp_stall;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = req_func ? ST_R_GAP : ST_P_DEB;
            end
         end
         ST_P_DEB:  state_in = drop ? ST_IDLE : ST_P_GAP;
         ST_P_GAP:  state_in = ST_P_INC;
         ST_P_INC:  state_in = ST_P_SPAN;
         ST_P_SPAN: state_in = ST_IDLE;
         ST_R_GAP:  state_in = alu_flags.res_gt_c ? ST_R_OUT : ST_R_IDLE;
         ST_R_IDLE: state_in = ST_R_CHK;
         ST_R_CHK: begin
            state_in = ((n_ff != '0) && alu_flags.res_lt_c) ? ST_R_SPAN : ST_R_OUT;
         end
         ST_R_SPAN: state_in = ST_R_ADD;
         ST_R_ADD:  state_in = ST_R_CHK;
         ST_R_OUT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and output control for each state.
   always_comb begin
      cur_slot_in      = cur_slot_ff;
      accepted_once_in = accepted_once_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      func_in          = func_ff;
      now_in           = now_ff;
      want_in          = want_ff;
      last_accept_in   = last_accept_ff;
      cnt_in           = cnt_ff;
      start_in         = start_ff;
      end_in           = end_ff;
      gap_in           = gap_ff;
      span_in          = span_ff;
      len_in           = len_ff;
      first_in         = first_ff;
      sum_in           = sum_ff;
      n_in             = n_ff;
      idx_in           = idx_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_len_in       = rsp_len_ff;
      rsp_start_in     = rsp_start_ff;
      mem_rd_en        = 1'b0;
      mem_rd_addr      = cur_slot_ff;
      mem_wr_en        = 1'b0;
      mem_wr_addr      = cur_slot_ff;
      mem_wr_data      = {cnt_ff, start_ff, end_ff};
      alu_op           = ALU_SUB;
      alu_a            = '0;
      alu_b            = '0;
      alu_c            = '0;

      unique case (state_ff)
         ST_IDLE: begin
            // Take the item and fetch the current interval.
            if (accept) begin
               func_in   = req_func;
               now_in    = req_sample_time;
               want_in   = req_window_request;
               mem_rd_en = 1'b1;
            end
         end
         ST_P_DEB: begin
            // Debounce against the last accepted pulse.
            alu_a    = now_ff;
            alu_b    = last_accept_ff;
            alu_c    = cfg.debounce;
            cnt_in   = rd_count;
            start_in = rd_start;
            end_in   = rd_end;
            if (!drop) begin
               last_accept_in   = now_ff;
               accepted_once_in = 1'b1;
            end
         end
         ST_P_GAP: begin
            // A long gap after a non-empty interval opens a fresh one.
            alu_a = now_ff;
            alu_b = end_ff;
            alu_c = cfg.min_interval;
            if (alu_flags.res_gt_c && (cnt_ff != '0)) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = next_slot;
               mem_wr_data = {COUNT_BITS'(0), end_ff, end_ff};
               cur_slot_in = next_slot;
               cnt_in      = '0;
               start_in    = end_ff;
            end
         end
         ST_P_INC: begin
            // Count the pulse and move the interval end.
            mem_wr_en   = 1'b1;
            mem_wr_data = {cnt_sat, start_ff, now_ff};
            cnt_in      = cnt_sat;
            end_in      = now_ff;
         end
         ST_P_SPAN: begin
            // Close the interval once its span exceeds the minimum.
            alu_a = end_ff;
            alu_b = start_ff;
            alu_c = cfg.min_interval;
            if (alu_flags.res_gt_c) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = next_slot;
               mem_wr_data = {COUNT_BITS'(0), end_ff, end_ff};
               cur_slot_in = next_slot;
            end
         end
         ST_R_GAP: begin
            // Gap since the newest end; a gap beyond the window is an idle read.
            alu_a  = now_ff;
            alu_b  = rd_end;
            alu_c  = want_ff;
            gap_in = alu_result;
            idx_in = cur_slot_ff;
            if (alu_flags.res_gt_c) begin
               sum_in   = '0;
               len_in   = alu_result;
               first_in = rd_end;
            end
         end
         ST_R_IDLE: begin
            // A gap longer than the minimum counts toward the window.
            alu_a    = gap_ff;
            alu_c    = cfg.min_interval;
            len_in   = alu_flags.res_gt_c ? gap_ff : '0;
            sum_in   = '0;
            first_in = '0;
            n_in     = N_BITS'(SLOT_COUNT);
         end
         ST_R_CHK: begin
            // Is the window still short of the request?
            alu_a = len_ff;
            alu_c = want_ff;
         end
         ST_R_SPAN: begin
            // Span of this interval; its count joins the sum.
            alu_a    = rd_end;
            alu_b    = rd_start;
            span_in  = alu_result;
            sum_in   = sum_ff + rd_count_wide[PULSE_COUNT_BITS-1:0];
            first_in = rd_start;
         end
         ST_R_ADD: begin
            // Add the span and fetch the next older interval.
            alu_op      = ALU_ADD;
            alu_a       = len_ff;
            alu_b       = span_ff;
            len_in      = alu_result;
            n_in        = n_ff - 1'b1;
            idx_in      = prev_idx;
            mem_rd_en   = 1'b1;
            mem_rd_addr = prev_idx;
         end
         ST_R_OUT: begin
            // Hand the result item to the output register when it is free.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = sum_ff;
               rsp_len_in   = len_ff;
               rsp_start_in = first_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cur_slot_ff      <= '0;
         accepted_once_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         cur_slot_ff      <= cur_slot_in;
         accepted_once_ff <= accepted_once_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      now_ff         <= now_in;
      want_ff        <= want_in;
      last_accept_ff <= last_accept_in;
      cnt_ff         <= cnt_in;
      start_ff       <= start_in;
      end_ff         <= end_in;
      gap_ff         <= gap_in;
      span_ff        <= span_in;
      len_ff         <= len_in;
      first_ff       <= first_in;
      sum_ff         <= sum_in;
      n_ff           <= n_in;
      idx_ff         <= idx_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_len_ff     <= rsp_len_in;
      rsp_start_ff   <= rsp_start_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pulse_count   = rsp_count_ff;
   assign rsp_window_length = rsp_len_ff;
   assign rsp_window_start  = rsp_start_ff;

   // A new result item only ever comes out of the output state of a read.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_R_OUT) && $past(func_ff))
      else $error("result item raised outside a read");

   // Only the pulse path writes the slot memory.
   assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == ST_P_GAP) || (state_ff == ST_P_INC) ||
                    (state_ff == ST_P_SPAN))
      else $error("slot memory written outside the pulse path");

   // The walk never visits more intervals than the ring holds.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_R_SPAN) |-> (n_ff != '0) && (n_ff <= N_BITS'(SLOT_COUNT)))
      else $error("interval walk ran past the ring");

   // A read and a write of the slot memory never share a cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(mem_rd_en && mem_wr_en))
      else $error("slot memory read and write collide");

endmodule

[hdl/tachometer_interval_ring.sv]
// Top level of the tachometer interval ring: configuration registers and unit wiring.
//
// Use: each input item on req_* is either a pulse event (func 0) stamped with
// the free-running timer value, or a read request (func 1) giving a look-back
// window. A pulse updates the ring of SLOT_COUNT intervals and returns nothing.
// A read returns one result item on rsp_*: summed count, covered length and
// start tick of the oldest interval used.
// Timing: one shared 32-bit add/subtract-and-compare unit does one operation
// per cycle, so an item holds the input channel for its whole run. A pulse
// runs the debounce, gap, count and span steps, ending after the debounce step
// when debounced away. A read checks the gap to the newest interval and, unless
// the gap is idle, walks k <= SLOT_COUNT intervals, three unit operations per interval.
// req_stall is high while an item is at work. A finished result sits in an
// output register, so the next item is accepted while rsp_stall holds it; a
// further read then waits in its last state until the register empties.
// Reset (synchronous, active high) clears the ring through per-slot valid bits,
// the current slot and debounce history, and restores the configuration
// registers; csr_ready is always high and unknown indexes are ignored.
module tachometer_interval_ring #(
   parameter int SLOT_COUNT = 8,
   parameter int COUNT_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_func,
   input  logic [tir_pkg::TICK_BITS-1:0]         req_sample_time,
   input  logic [tir_pkg::TICK_BITS-1:0]         req_window_request,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [tir_pkg::PULSE_COUNT_BITS-1:0]  rsp_pulse_count,
   output logic [tir_pkg::TICK_BITS-1:0]         rsp_window_length,
   output logic [tir_pkg::TICK_BITS-1:0]         rsp_window_start,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tir_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [tir_pkg::TICK_BITS-1:0]         csr_data
);
   import tir_pkg::*;

   localparam int IDX_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int ENT_BITS = COUNT_BITS + 2 * TICK_BITS;

   cfg_type cfg_ff;

   logic                  mem_rd_en;
   logic [IDX_BITS-1:0]   mem_rd_addr;
   logic [ENT_BITS-1:0]   mem_rd_data;
   logic                  mem_wr_en;
   logic [IDX_BITS-1:0]   mem_wr_addr;
   logic [ENT_BITS-1:0]   mem_wr_data;
   alu_op_type            alu_op;
   logic [TICK_BITS-1:0]  alu_a;
   logic [TICK_BITS-1:0]  alu_b;
   logic [TICK_BITS-1:0]  alu_c;
   logic [TICK_BITS-1:0]  alu_result;
   alu_flags_type         alu_flags;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_interval <= TICK_BITS'(1000);
         cfg_ff.debounce     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MIN_INTERVAL: cfg_ff.min_interval <= csr_data;
            CSR_DEBOUNCE:     cfg_ff.debounce     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   tir_slot_mem #(
      .DEPTH     (SLOT_COUNT),
      .WIDTH     (ENT_BITS),
      .ADDR_BITS (IDX_BITS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   tir_alu u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .c      (alu_c),
      .result (alu_result),
      .flags  (alu_flags)
   );

   tir_seq #(
      .SLOT_COUNT (SLOT_COUNT),
      .COUNT_BITS (COUNT_BITS),
      .IDX_BITS   (IDX_BITS),
      .ENT_BITS   (ENT_BITS)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_sample_time    (req_sample_time),
      .req_window_request (req_window_request),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pulse_count    (rsp_pulse_count),
      .rsp_window_length  (rsp_window_length),
      .rsp_window_start   (rsp_window_start),
      .cfg                (cfg_ff),
      .mem_rd_en          (mem_rd_en),
      .mem_rd_addr        (mem_rd_addr),
      .mem_rd_data        (mem_rd_data),
      .mem_wr_en          (mem_wr_en),
      .mem_wr_addr        (mem_wr_addr),
      .mem_wr_data        (mem_wr_data),
      .alu_op             (alu_op),
      .alu_a              (alu_a),
      .alu_b              (alu_b),
      .alu_c              (alu_c),
      .alu_result         (alu_result),
      .alu_flags          (alu_flags)
   );

endmodule
